// ===== rtl/core/vars_pkg.sv =====
package vars_pkg;

   localparam int COORD_BITS   = 32;
   localparam int ANGLE_BITS   = 16;
   localparam int FACTOR_BITS  = 16;
   localparam int CORDIC_STEPS = 28;
   localparam int CORDIC_BITS  = 34;
   localparam int RESID_BITS   = 33;
   localparam int TRIG_BITS    = 32;
   localparam int TRIG_FRAC    = 30;
   localparam int SCALE_FRAC   = 8;
   localparam int CORDIC_START = 652032874;
   localparam int ONE_Q30      = 1 << TRIG_FRAC;

   typedef enum logic [1:0] {
      FUNC_ROT_X = 2'd0,
      FUNC_ROT_Y = 2'd1,
      FUNC_ROT_Z = 2'd2,
      FUNC_SCALE = 2'd3
   } func_type;

   typedef struct packed {
      func_type                       func;
      logic signed [COORD_BITS-1:0]   in_x;
      logic signed [COORD_BITS-1:0]   in_y;
      logic signed [COORD_BITS-1:0]   in_z;
      logic        [ANGLE_BITS-1:0]   turn_angle;
      logic signed [FACTOR_BITS-1:0]  factor_x;
      logic signed [FACTOR_BITS-1:0]  factor_y;
      logic signed [FACTOR_BITS-1:0]  factor_z;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] out_x;
      logic signed [COORD_BITS-1:0] out_y;
      logic signed [COORD_BITS-1:0] out_z;
   } rsp_type;

   // atan(2^-i), 2^32 per turn
   function automatic logic [29:0] atan_turn(input int idx);
      logic [29:0] r;
      case (idx)
         0:       r = 30'h20000000;
         1:       r = 30'h12E4051E;
         2:       r = 30'h09FB385B;
         3:       r = 30'h051111D4;
         4:       r = 30'h028B0D43;
         5:       r = 30'h0145D7E1;
         6:       r = 30'h00A2F61E;
         7:       r = 30'h00517C55;
         8:       r = 30'h0028BE53;
         9:       r = 30'h00145F2F;
         10:      r = 30'h000A2F98;
         11:      r = 30'h000517CC;
         12:      r = 30'h00028BE6;
         13:      r = 30'h000145F3;
         14:      r = 30'h0000A2FA;
         15:      r = 30'h0000517D;
         16:      r = 30'h000028BE;
         17:      r = 30'h0000145F;
         18:      r = 30'h00000A30;
         19:      r = 30'h00000518;
         20:      r = 30'h0000028C;
         21:      r = 30'h00000146;
         22:      r = 30'h000000A3;
         23:      r = 30'h00000051;
         24:      r = 30'h00000029;
         25:      r = 30'h00000014;
         26:      r = 30'h0000000A;
         27:      r = 30'h00000005;
         default: r = 30'h0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/core/vector_axis_rotate_scale_top.sv =====
// rsp_valid pulses once the taken beat has passed through every pipeline register
// (29 CORDIC register stages, then trig, operand, product, sum, round, saturate).
// Throughput: one beat per cycle; busy is low whenever reset is low.
// Reset: synchronous, clears the valid bits of every stage; beats in flight are dropped.
// The receiver cannot stall: each result is on rsp_data for exactly one cycle.
module vector_axis_rotate_scale_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  vars_pkg::req_type req_data,
   output logic              busy,
   output logic              rsp_valid,
   output vars_pkg::rsp_type rsp_data
);

   localparam int CW    = vars_pkg::COORD_BITS;
   localparam int AW    = vars_pkg::ANGLE_BITS;
   localparam int FW    = vars_pkg::FACTOR_BITS;
   localparam int STEPS = vars_pkg::CORDIC_STEPS;
   localparam int CB    = vars_pkg::CORDIC_BITS;
   localparam int ZB    = vars_pkg::RESID_BITS;
   localparam int TB    = vars_pkg::TRIG_BITS;
   localparam int LO    = CW / 2;
   localparam int HI    = CW - LO;
   localparam int PHW   = HI + TB;
   localparam int PLW   = LO + 1 + TB;
   localparam int SHW   = PHW + 1;
   localparam int SLW   = PLW + 1;
   localparam int TW    = CW + 36;
   localparam int LATENCY = STEPS + 7;

   localparam logic signed [TB-1:0] ONE_T = TB'(vars_pkg::ONE_Q30);
   localparam logic signed [CB-1:0] ONE_C = CB'(vars_pkg::ONE_Q30);
   localparam logic signed [CW-1:0] MAX_V = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] MIN_V = {1'b1, {(CW-1){1'b0}}};
   localparam logic signed [TW-1:0] RND_TRIG = TW'(1) <<< (vars_pkg::TRIG_FRAC - 1);
   localparam logic signed [TW-1:0] RND_SCALE = TW'(1) <<< (vars_pkg::SCALE_FRAC - 1);

   logic accept;
   assign busy   = reset;
   assign accept = start & ~busy;

   // ---------------- angle prep and CORDIC ----------------
   logic [31:0] ang_u, ang_r, ang_d;
   logic [1:0]  ang_q;
   assign ang_u = {req_data.turn_angle, {(32-AW){1'b0}}};
   assign ang_r = ang_u + 32'h2000_0000;
   assign ang_q = ang_r[31:30];
   assign ang_d = ang_u - {ang_q, 30'd0};

   logic signed [CB-1:0] cx_ff [0:STEPS];
   logic signed [CB-1:0] cy_ff [0:STEPS];
   logic signed [ZB-1:0] cz_ff [0:STEPS];
   logic [1:0]           cq_ff [0:STEPS];
   vars_pkg::req_type    cd_ff [0:STEPS];
   logic                 cv_ff [0:STEPS];
   logic signed [CB-1:0] cx_in [0:STEPS];
   logic signed [CB-1:0] cy_in [0:STEPS];
   logic signed [ZB-1:0] cz_in [0:STEPS];
   logic [1:0]           cq_in [0:STEPS];
   vars_pkg::req_type    cd_in [0:STEPS];
   logic                 cv_in [0:STEPS];

   assign cx_in[0] = CB'(vars_pkg::CORDIC_START);
   assign cy_in[0] = '0;
   assign cz_in[0] = {ang_d[31], ang_d};
   assign cq_in[0] = ang_q;
   assign cd_in[0] = req_data;
   assign cv_in[0] = accept;

   for (genvar k = 0; k < STEPS; k++) begin : g_cordic
      logic signed [CB-1:0] sh_x, sh_y;
      logic signed [ZB-1:0] at;
      logic                 pos;
      assign sh_x = cx_ff[k] >>> k;
      assign sh_y = cy_ff[k] >>> k;
      assign at   = ZB'(vars_pkg::atan_turn(k));
      assign pos  = ~cz_ff[k][ZB-1];
      assign cx_in[k+1] = pos ? cx_ff[k] - sh_y : cx_ff[k] + sh_y;
      assign cy_in[k+1] = pos ? cy_ff[k] + sh_x : cy_ff[k] - sh_x;
      assign cz_in[k+1] = pos ? cz_ff[k] - at : cz_ff[k] + at;
      assign cq_in[k+1] = cq_ff[k];
      assign cd_in[k+1] = cd_ff[k];
      assign cv_in[k+1] = cv_ff[k];
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= STEPS; k++) begin
         cx_ff[k] <= cx_in[k];
         cy_ff[k] <= cy_in[k];
         cz_ff[k] <= cz_in[k];
         cq_ff[k] <= cq_in[k];
         cd_ff[k] <= cd_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= STEPS; k++) cv_ff[k] <= 1'b0;
      end else begin
         for (int k = 0; k <= STEPS; k++) cv_ff[k] <= cv_in[k];
      end
   end

   // ---------------- clamp and quadrant ----------------
   logic signed [TB-1:0] cl_x, cl_y;
   logic signed [TB-1:0] tr_c_in, tr_s_in, tr_ns_in;
   logic signed [TB-1:0] tr_c_ff, tr_s_ff, tr_ns_ff;
   vars_pkg::req_type    tr_d_ff;
   logic                 tr_v_ff;

   always_comb begin
      if (cx_ff[STEPS] > ONE_C)       cl_x = ONE_T;
      else if (cx_ff[STEPS] < -ONE_C) cl_x = -ONE_T;
      else                            cl_x = TB'(cx_ff[STEPS]);
      if (cy_ff[STEPS] > ONE_C)       cl_y = ONE_T;
      else if (cy_ff[STEPS] < -ONE_C) cl_y = -ONE_T;
      else                            cl_y = TB'(cy_ff[STEPS]);
      case (cq_ff[STEPS])
         2'd0:    begin tr_c_in = cl_x;  tr_s_in = cl_y;  end
         2'd1:    begin tr_c_in = -cl_y; tr_s_in = cl_x;  end
         2'd2:    begin tr_c_in = -cl_x; tr_s_in = -cl_y; end
         default: begin tr_c_in = cl_y;  tr_s_in = -cl_x; end
      endcase
      tr_ns_in = -tr_s_in;
   end

   always_ff @(posedge clock) begin
      tr_c_ff  <= tr_c_in;
      tr_s_ff  <= tr_s_in;
      tr_ns_ff <= tr_ns_in;
      tr_d_ff  <= cd_ff[STEPS];
   end

   // ---------------- operand select ----------------
   // each axis: a*ta + b*tb; pass-through axis uses ta = 1.0, b = 0
   logic signed [CW-1:0] op_a_in  [0:2];
   logic signed [TB-1:0] op_ta_in [0:2];
   logic signed [CW-1:0] op_b_in  [0:2];
   logic signed [TB-1:0] op_tb_in [0:2];
   logic signed [CW-1:0] op_a_ff  [0:2];
   logic signed [TB-1:0] op_ta_ff [0:2];
   logic signed [CW-1:0] op_b_ff  [0:2];
   logic signed [TB-1:0] op_tb_ff [0:2];
   logic                 op_scl_ff, op_v_ff;

   always_comb begin
      op_a_in[0] = tr_d_ff.in_x;
      op_a_in[1] = tr_d_ff.in_y;
      op_a_in[2] = tr_d_ff.in_z;
      for (int i = 0; i < 3; i++) begin
         op_ta_in[i] = ONE_T;
         op_b_in[i]  = '0;
         op_tb_in[i] = '0;
      end
      case (tr_d_ff.func)
         vars_pkg::FUNC_ROT_X: begin
            op_ta_in[1] = tr_c_ff;
            op_b_in[1]  = tr_d_ff.in_z;
            op_tb_in[1] = tr_ns_ff;
            op_a_in[2]  = tr_d_ff.in_y;
            op_ta_in[2] = tr_s_ff;
            op_b_in[2]  = tr_d_ff.in_z;
            op_tb_in[2] = tr_c_ff;
         end
         vars_pkg::FUNC_ROT_Y: begin
            op_ta_in[0] = tr_c_ff;
            op_b_in[0]  = tr_d_ff.in_z;
            op_tb_in[0] = tr_s_ff;
            op_ta_in[2] = tr_c_ff;
            op_b_in[2]  = tr_d_ff.in_x;
            op_tb_in[2] = tr_ns_ff;
         end
         vars_pkg::FUNC_ROT_Z: begin
            op_ta_in[0] = tr_c_ff;
            op_b_in[0]  = tr_d_ff.in_y;
            op_tb_in[0] = tr_ns_ff;
            op_a_in[1]  = tr_d_ff.in_x;
            op_ta_in[1] = tr_s_ff;
            op_b_in[1]  = tr_d_ff.in_y;
            op_tb_in[1] = tr_c_ff;
         end
         vars_pkg::FUNC_SCALE: begin
            op_ta_in[0] = {{(TB-FW){tr_d_ff.factor_x[FW-1]}}, tr_d_ff.factor_x};
            op_ta_in[1] = {{(TB-FW){tr_d_ff.factor_y[FW-1]}}, tr_d_ff.factor_y};
            op_ta_in[2] = {{(TB-FW){tr_d_ff.factor_z[FW-1]}}, tr_d_ff.factor_z};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         op_a_ff[i]  <= op_a_in[i];
         op_ta_ff[i] <= op_ta_in[i];
         op_b_ff[i]  <= op_b_in[i];
         op_tb_ff[i] <= op_tb_in[i];
      end
      op_scl_ff <= (tr_d_ff.func == vars_pkg::FUNC_SCALE);
   end

   // ---------------- products, sums, rounding, saturation ----------------
   logic signed [PHW-1:0] pr_ha_ff [0:2];
   logic signed [PLW-1:0] pr_la_ff [0:2];
   logic signed [PHW-1:0] pr_hb_ff [0:2];
   logic signed [PLW-1:0] pr_lb_ff [0:2];
   logic signed [PHW-1:0] pr_ha_in [0:2];
   logic signed [PLW-1:0] pr_la_in [0:2];
   logic signed [PHW-1:0] pr_hb_in [0:2];
   logic signed [PLW-1:0] pr_lb_in [0:2];
   logic signed [SHW-1:0] sm_h_in  [0:2];
   logic signed [SLW-1:0] sm_l_in  [0:2];
   logic signed [SHW-1:0] sm_h_ff  [0:2];
   logic signed [SLW-1:0] sm_l_ff  [0:2];
   logic signed [TW-1:0]  rn_in    [0:2];
   logic signed [TW-1:0]  rn_ff    [0:2];
   logic signed [CW-1:0]  st_in    [0:2];
   logic                  pr_scl_ff, sm_scl_ff;
   logic                  pr_v_ff, sm_v_ff, rn_v_ff;

   for (genvar i = 0; i < 3; i++) begin : g_axis
      logic signed [HI-1:0]  a_hi, b_hi;
      logic signed [LO:0]    a_lo, b_lo;
      logic signed [TW-1:0]  tot;
      logic [TW-CW:0]        top;

      assign a_hi = op_a_ff[i][CW-1:LO];
      assign b_hi = op_b_ff[i][CW-1:LO];
      assign a_lo = {1'b0, op_a_ff[i][LO-1:0]};
      assign b_lo = {1'b0, op_b_ff[i][LO-1:0]};

      assign pr_ha_in[i] = PHW'(a_hi) * PHW'(op_ta_ff[i]);
      assign pr_la_in[i] = PLW'(a_lo) * PLW'(op_ta_ff[i]);
      assign pr_hb_in[i] = PHW'(b_hi) * PHW'(op_tb_ff[i]);
      assign pr_lb_in[i] = PLW'(b_lo) * PLW'(op_tb_ff[i]);

      assign sm_h_in[i] = SHW'(pr_ha_ff[i]) + SHW'(pr_hb_ff[i]);
      assign sm_l_in[i] = SLW'(pr_la_ff[i]) + SLW'(pr_lb_ff[i]);

      assign tot = (TW'(sm_h_ff[i]) <<< LO) + TW'(sm_l_ff[i])
                   + (sm_scl_ff ? RND_SCALE : RND_TRIG);
      assign rn_in[i] = sm_scl_ff ? (tot >>> vars_pkg::SCALE_FRAC)
                                  : (tot >>> vars_pkg::TRIG_FRAC);

      assign top = rn_ff[i][TW-1:CW-1];
      assign st_in[i] = ((&top) || !(|top)) ? rn_ff[i][CW-1:0]
                      : (rn_ff[i][TW-1] ? MIN_V : MAX_V);
   end

   vars_pkg::rsp_type rsp_in, rsp_ff;
   logic              rsp_v_ff;

   assign rsp_in.out_x = st_in[0];
   assign rsp_in.out_y = st_in[1];
   assign rsp_in.out_z = st_in[2];

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         pr_ha_ff[i] <= pr_ha_in[i];
         pr_la_ff[i] <= pr_la_in[i];
         pr_hb_ff[i] <= pr_hb_in[i];
         pr_lb_ff[i] <= pr_lb_in[i];
         sm_h_ff[i]  <= sm_h_in[i];
         sm_l_ff[i]  <= sm_l_in[i];
         rn_ff[i]    <= rn_in[i];
      end
      pr_scl_ff <= op_scl_ff;
      sm_scl_ff <= pr_scl_ff;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tr_v_ff  <= 1'b0;
         op_v_ff  <= 1'b0;
         pr_v_ff  <= 1'b0;
         sm_v_ff  <= 1'b0;
         rn_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         tr_v_ff  <= cv_ff[STEPS];
         op_v_ff  <= tr_v_ff;
         pr_v_ff  <= op_v_ff;
         sm_v_ff  <= pr_v_ff;
         rn_v_ff  <= sm_v_ff;
         rsp_v_ff <= rn_v_ff;
      end
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

   // ---------------- assertions ----------------
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(cv_ff[0], LATENCY - 1))
      else $error("result beat without a matching accepted beat");

   a_trig_range: assert property (@(posedge clock) disable iff (reset)
      tr_v_ff |-> (tr_c_ff <= ONE_T && tr_c_ff >= -ONE_T &&
                   tr_s_ff <= ONE_T && tr_s_ff >= -ONE_T && tr_ns_ff == -tr_s_ff))
      else $error("sine or cosine outside unit range");

   a_no_accept_in_reset: assert property (@(posedge clock)
      reset |=> !cv_ff[0])
      else $error("beat entered the pipe during reset");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   localparam int     LIMIT      = 60000;
   localparam int     DRAIN      = 40;
   localparam int     N_RANDOM   = 1550;
   localparam longint TRIG_START = 64'sd652032874;
   localparam longint TRIG_ONE   = 64'sd1073741824;
   localparam longint HALF_Q30   = 64'sd536870912;
   localparam longint COORD_MAX  = 64'sd2147483647;
   localparam longint COORD_MIN  = -64'sd2147483648;

   // atan(2^-i), 2^32 per turn
   localparam longint ATAN_TURN [28] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
      64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
      64'h00000014, 64'h0000000A, 64'h00000005
   };

   class xform_board;
      vars_pkg::rsp_type pending_points[$];
      int                errors;

      function longint clip_coord(longint v);
         if (v > COORD_MAX) begin
            return COORD_MAX;
         end
         if (v < COORD_MIN) begin
            return COORD_MIN;
         end
         return v;
      endfunction

      function longint clip_trig(longint t);
         if (t > TRIG_ONE) begin
            return TRIG_ONE;
         end
         if (t < -TRIG_ONE) begin
            return -TRIG_ONE;
         end
         return t;
      endfunction

      function void trig_of(input logic [vars_pkg::ANGLE_BITS-1:0] ang,
                            output longint c, output longint s);
         bit [31:0] u;
         bit [31:0] t;
         bit [31:0] d;
         bit [1:0]  q;
         longint    x;
         longint    y;
         longint    z;
         longint    nx;
         u = {ang, 16'h0000};
         t = u + 32'h2000_0000;
         q = t[31:30];
         d = u - {q, 30'h0};
         z = longint'($signed(d));
         x = TRIG_START;
         y = 0;
         for (int i = 0; i < 28; i++) begin
            if (z >= 0) begin
               nx = x - (y >>> i);
               y  = y + (x >>> i);
               z  = z - ATAN_TURN[i];
            end else begin
               nx = x + (y >>> i);
               y  = y - (x >>> i);
               z  = z + ATAN_TURN[i];
            end
            x = nx;
         end
         x = clip_trig(x);
         y = clip_trig(y);
         case (q)
            2'd0: begin
               c = x;
               s = y;
            end
            2'd1: begin
               c = -y;
               s = x;
            end
            2'd2: begin
               c = -x;
               s = -y;
            end
            default: begin
               c = y;
               s = -x;
            end
         endcase
      endfunction

      function longint mac_q30(longint a, longint ta, longint b, longint tb);
         return (a * ta + b * tb + HALF_Q30) >>> 30;
      endfunction

      function longint scale_q8(longint v, longint f);
         return (v * f + 64'sd128) >>> 8;
      endfunction

      function vars_pkg::rsp_type transform_point(vars_pkg::req_type r);
         longint            x;
         longint            y;
         longint            z;
         longint            rx;
         longint            ry;
         longint            rz;
         longint            c;
         longint            s;
         vars_pkg::rsp_type p;
         x  = longint'($signed(r.in_x));
         y  = longint'($signed(r.in_y));
         z  = longint'($signed(r.in_z));
         rx = x;
         ry = y;
         rz = z;
         if (r.func == vars_pkg::FUNC_SCALE) begin
            rx = scale_q8(x, longint'($signed(r.factor_x)));
            ry = scale_q8(y, longint'($signed(r.factor_y)));
            rz = scale_q8(z, longint'($signed(r.factor_z)));
         end else begin
            trig_of(r.turn_angle, c, s);
            case (r.func)
               vars_pkg::FUNC_ROT_X: begin
                  ry = mac_q30(y, c, z, -s);
                  rz = mac_q30(y, s, z, c);
               end
               vars_pkg::FUNC_ROT_Y: begin
                  rx = mac_q30(x, c, z, s);
                  rz = mac_q30(z, c, x, -s);
               end
               default: begin
                  rx = mac_q30(x, c, y, -s);
                  ry = mac_q30(x, s, y, c);
               end
            endcase
         end
         p.out_x = 32'(clip_coord(rx));
         p.out_y = 32'(clip_coord(ry));
         p.out_z = 32'(clip_coord(rz));
         return p;
      endfunction

      function void note_beat(vars_pkg::req_type r);
         pending_points.push_back(transform_point(r));
      endfunction

      function void check_beat(vars_pkg::rsp_type got);
         vars_pkg::rsp_type want;
         if (pending_points.size() == 0) begin
            $error("unexpected result beat: out_x %0d out_y %0d out_z %0d",
                   got.out_x, got.out_y, got.out_z);
            errors++;
            return;
         end
         want = pending_points.pop_front();
         if (got.out_x !== want.out_x) begin
            $error("out_x expected %0d actual %0d", want.out_x, got.out_x);
            errors++;
         end
         if (got.out_y !== want.out_y) begin
            $error("out_y expected %0d actual %0d", want.out_y, got.out_y);
            errors++;
         end
         if (got.out_z !== want.out_z) begin
            $error("out_z expected %0d actual %0d", want.out_z, got.out_z);
            errors++;
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   vars_pkg::req_type req_data;
   logic              busy;
   logic              rsp_valid;
   vars_pkg::rsp_type rsp_data;

   xform_board board = new;
   int         cycles = 0;
   bit         no_gaps = 1'b0;

   vector_axis_rotate_scale_top DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("vector_axis_rotate_scale_top: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            board.note_beat(req_data);
         end
         if (rsp_valid) begin
            board.check_beat(rsp_data);
         end
      end
   end

   function automatic vars_pkg::req_type make_req(vars_pkg::func_type f, logic [31:0] x,
                                                  logic [31:0] y, logic [31:0] z,
                                                  logic [15:0] a, logic [15:0] fx,
                                                  logic [15:0] fy, logic [15:0] fz);
      vars_pkg::req_type r;
      r.func       = f;
      r.in_x       = x;
      r.in_y       = y;
      r.in_z       = z;
      r.turn_angle = a;
      r.factor_x   = fx;
      r.factor_y   = fy;
      r.factor_z   = fz;
      return r;
   endfunction

   function automatic logic [31:0] rand_coord();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 5))
         0: v = {{12{v[19]}}, v[19:0]};
         1: v = {{20{v[11]}}, v[11:0]};
         2: begin
            case ($urandom_range(0, 4))
               0: v = 32'h7FFF_FFFF;
               1: v = 32'h8000_0000;
               2: v = 32'h0000_0000;
               3: v = 32'hFFFF_FFFF;
               default: v = 32'h0001_0000;
            endcase
         end
         default: ;
      endcase
      return v;
   endfunction

   function automatic logic [15:0] rand_angle();
      logic [15:0] a;
      a = $urandom;
      case ($urandom_range(0, 3))
         0: a = {a[15:14], 14'h0} + 16'($signed(4'($urandom)));
         1: a = {a[15:14], 14'h2000} + 16'($signed(4'($urandom)));
         default: ;
      endcase
      return a;
   endfunction

   function automatic logic [15:0] rand_factor();
      logic [15:0] f;
      f = $urandom;
      case ($urandom_range(0, 5))
         0: f = {{6{f[9]}}, f[9:0]};
         1: begin
            case ($urandom_range(0, 3))
               0: f = 16'h0100;
               1: f = 16'h8000;
               2: f = 16'h7FFF;
               default: f = 16'h0000;
            endcase
         end
         default: ;
      endcase
      return f;
   endfunction

   // entered and left at a falling edge
   task automatic send_beat(input vars_pkg::req_type r);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start    = 1'b1;
      req_data = r;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   initial begin
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      send_beat(make_req(vars_pkg::FUNC_ROT_X, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                         16'h0000, 16'h0, 16'h0, 16'h0));
      send_beat(make_req(vars_pkg::FUNC_ROT_X, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         16'h2000, 16'h7FFF, 16'h8000, 16'hFFFF));
      send_beat(make_req(vars_pkg::FUNC_ROT_X, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         16'hE000, 16'h0, 16'h0, 16'h0));
      send_beat(make_req(vars_pkg::FUNC_ROT_X, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         16'hA000, 16'h0, 16'h0, 16'h0));
      send_beat(make_req(vars_pkg::FUNC_ROT_X, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000,
                         16'hFFFF, 16'h0, 16'h0, 16'h0));
      send_beat(make_req(vars_pkg::FUNC_ROT_Y, 32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000,
                         16'h4000, 16'h0, 16'h0, 16'h0));
      send_beat(make_req(vars_pkg::FUNC_ROT_Y, 32'h7FFF_FFFF, 32'h1234_5678, 32'h8000_0000,
                         16'h8000, 16'h0, 16'h0, 16'h0));
      send_beat(make_req(vars_pkg::FUNC_ROT_Y, 32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF,
                         16'h6000, 16'h0, 16'h0, 16'h0));
      send_beat(make_req(vars_pkg::FUNC_ROT_Y, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                         16'h2000, 16'h0, 16'h0, 16'h0));
      send_beat(make_req(vars_pkg::FUNC_ROT_Z, 32'h0010_0000, 32'hFFF0_0000, 32'h7FFF_FFFF,
                         16'hC000, 16'h0, 16'h0, 16'h0));
      send_beat(make_req(vars_pkg::FUNC_ROT_Z, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000,
                         16'h1FFF, 16'h0, 16'h0, 16'h0));
      send_beat(make_req(vars_pkg::FUNC_ROT_Z, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                         16'hE000, 16'h0100, 16'h8000, 16'h7FFF));
      send_beat(make_req(vars_pkg::FUNC_ROT_Z, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000,
                         16'h0001, 16'h0, 16'h0, 16'h0));
      send_beat(make_req(vars_pkg::FUNC_ROT_Z, 32'hFFFF_0000, 32'h0000_8000, 32'h0000_0001,
                         16'h5FFF, 16'h0, 16'h0, 16'h0));
      send_beat(make_req(vars_pkg::FUNC_SCALE, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                         16'h0000, 16'h0100, 16'h0100, 16'h0100));
      send_beat(make_req(vars_pkg::FUNC_SCALE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                         16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h8000));
      send_beat(make_req(vars_pkg::FUNC_SCALE, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0003,
                         16'h4000, 16'h0080, 16'h0080, 16'hFF80));
      send_beat(make_req(vars_pkg::FUNC_SCALE, 32'h1234_5678, 32'h8765_4321, 32'h7FFF_FFFF,
                         16'h8000, 16'h0000, 16'hFFFF, 16'h0001));
      send_beat(make_req(vars_pkg::FUNC_SCALE, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0000,
                         16'h2000, 16'hFF00, 16'h8000, 16'h7FFF));

      for (int n = 0; n < N_RANDOM; n++) begin
         if (n % 64 == 0) begin
            no_gaps = ($urandom_range(0, 2) == 0);
         end
         send_beat(make_req(vars_pkg::func_type'($urandom_range(0, 3)), rand_coord(),
                            rand_coord(), rand_coord(), rand_angle(), rand_factor(),
                            rand_factor(), rand_factor()));
      end
      start = 1'b0;

      while (board.pending_points.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      if (board.errors == 0 && board.pending_points.size() == 0) begin
         $display("vector_axis_rotate_scale_top: match");
      end else begin
         $display("vector_axis_rotate_scale_top: mismatch");
      end
      $finish;
   end

endmodule
